// ----- design/bwtr_pkg.sv -----
// ----------------------------------------------------------------------------
// bwtr_pkg
// Shared constants and controller/datapath interface types for the
// block-sorting transform with run-length coding.
// ----------------------------------------------------------------------------
package bwtr_pkg;

  localparam int MAX_LEN_DEF = 32;
  localparam int BYTE_W      = 8;
  localparam int PIDX_W      = 6;
  localparam int CNT_W       = 7;

  typedef struct packed {
    logic load_en;
    logic i_init;
    logic j_init;
    logic cmp_step;
    logic j_next;
    logic last_set;
    logic last_wr;
    logic emit_pidx;
    logic scan_init;
    logic scan_first;
    logic scan_cmp;
    logic emit_run;
  } bwtr_cmd_t;

  typedef struct packed {
    logic cmp_lt;
    logic cmp_gt;
    logic cmp_end;
    logic j_last;
    logic i_last;
    logic scan_end;
    logic sym_match;
    logic run_final;
    logic out_free;
  } bwtr_sts_t;

endpackage

// ----- design/bwtr_dp.sv -----
// ----------------------------------------------------------------------------
// bwtr_dp
// Datapath: line store, rotation rank counting, last-column store, run
// scanner and output register.
// ----------------------------------------------------------------------------
module bwtr_dp
  import bwtr_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bwtr_cmd_t                cmd,
  output bwtr_sts_t                sts,
  input  logic [BYTE_W-1:0]        in_data_byte,
  input  logic                     in_end_of_line,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_kind,
  output logic [PIDX_W-1:0]        out_primary_index,
  output logic [CNT_W-1:0]         out_run_count,
  output logic [BYTE_W-1:0]        out_run_symbol,
  output logic                     out_truncated,
  output logic                     out_final_result
);

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int LEN_W = $clog2(MAX_LEN + 1);

  logic [BYTE_W-1:0] store_mem [MAX_LEN];
  logic [BYTE_W-1:0] lc_mem    [MAX_LEN];

  logic [LEN_W-1:0]  len_r;
  logic              ovf_r;
  logic              out_valid_r;
  logic [IDX_W-1:0]  i_r, j_r, k_r, pa_r, pb_r, rank_r, pidx_r;
  logic [LEN_W-1:0]  s_r, cnt_r;
  logic [BYTE_W-1:0] sym_r, da_r, db_r, lcd_r;
  logic [LEN_W-1:0]  n_m1;
  logic [IDX_W-1:0]  n_m1_i;
  logic              room;

  assign n_m1   = len_r - LEN_W'(1);
  assign n_m1_i = n_m1[IDX_W-1:0];
  assign room   = len_r < LEN_W'(MAX_LEN);

  assign sts.cmp_lt    = da_r < db_r;
  assign sts.cmp_gt    = da_r > db_r;
  assign sts.cmp_end   = k_r == n_m1_i;
  assign sts.j_last    = j_r == n_m1_i;
  assign sts.i_last    = i_r == n_m1_i;
  assign sts.scan_end  = (s_r + LEN_W'(1)) == len_r;
  assign sts.sym_match = lcd_r == sym_r;
  assign sts.run_final = s_r == len_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.load_en && room) begin
      store_mem[len_r[IDX_W-1:0]] <= in_data_byte;
    end
    da_r <= store_mem[pa_r];
    db_r <= store_mem[pb_r];
    if (cmd.last_wr) begin
      lc_mem[rank_r] <= da_r;
    end
    lcd_r <= lc_mem[s_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_en) begin
        if (room) begin
          len_r <= len_r + LEN_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.emit_run && sts.run_final) begin
        len_r <= '0;
        ovf_r <= 1'b0;
      end
      if (cmd.emit_pidx || cmd.emit_run) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en && in_end_of_line) begin
      i_r <= '0;
    end
    if (cmd.i_init) begin
      j_r    <= '0;
      rank_r <= '0;
    end
    if (cmd.j_init) begin
      pa_r <= i_r;
      pb_r <= j_r;
      k_r  <= '0;
    end
    if (cmd.cmp_step) begin
      if (da_r > db_r) begin
        rank_r <= rank_r + IDX_W'(1);
      end else if (da_r == db_r) begin
        if (k_r == n_m1_i) begin
          if (j_r < i_r) begin
            rank_r <= rank_r + IDX_W'(1);
          end
        end else begin
          k_r  <= k_r + IDX_W'(1);
          pa_r <= (pa_r == n_m1_i) ? '0 : pa_r + IDX_W'(1);
          pb_r <= (pb_r == n_m1_i) ? '0 : pb_r + IDX_W'(1);
        end
      end
    end
    if (cmd.j_next) begin
      j_r <= j_r + IDX_W'(1);
    end
    if (cmd.last_set) begin
      pa_r <= (i_r == '0) ? n_m1_i : i_r - IDX_W'(1);
    end
    if (cmd.last_wr) begin
      if (i_r == '0) begin
        pidx_r <= rank_r;
      end
      i_r <= i_r + IDX_W'(1);
    end
    if (cmd.scan_init) begin
      s_r <= '0;
    end
    if (cmd.scan_first) begin
      sym_r <= lcd_r;
      cnt_r <= LEN_W'(1);
      s_r   <= s_r + LEN_W'(1);
    end
    if (cmd.scan_cmp && sts.sym_match) begin
      cnt_r <= cnt_r + LEN_W'(1);
      s_r   <= s_r + LEN_W'(1);
    end
    if (cmd.emit_pidx) begin
      out_kind          <= 1'b0;
      out_primary_index <= PIDX_W'(pidx_r);
      out_run_count     <= '0;
      out_run_symbol    <= '0;
      out_truncated     <= ovf_r;
      out_final_result  <= 1'b0;
    end else if (cmd.emit_run) begin
      out_kind          <= 1'b1;
      out_primary_index <= '0;
      out_run_count     <= CNT_W'(cnt_r);
      out_run_symbol    <= sym_r;
      out_truncated     <= ovf_r;
      out_final_result  <= sts.run_final;
    end
  end

endmodule

// ----- design/bwtr_ctrl.sv -----
// ----------------------------------------------------------------------------
// bwtr_ctrl
// Controller: sequences line load, rotation ranking, last-column build and
// run-length scan.
// ----------------------------------------------------------------------------
module bwtr_ctrl
  import bwtr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_end_of_line,
  output logic      in_stall,
  input  bwtr_sts_t sts,
  output bwtr_cmd_t cmd
);

  typedef enum logic [15:0] {
    S_LOAD       = 16'h0001,
    S_I_INIT     = 16'h0002,
    S_J_INIT     = 16'h0004,
    S_RD         = 16'h0008,
    S_CMP        = 16'h0010,
    S_J_NEXT     = 16'h0020,
    S_LAST_SET   = 16'h0040,
    S_LAST_RD    = 16'h0080,
    S_LAST_WR    = 16'h0100,
    S_EMIT_PIDX  = 16'h0200,
    S_SCAN_INIT  = 16'h0400,
    S_SCAN_RD    = 16'h0800,
    S_SCAN_FIRST = 16'h1000,
    S_SCAN_RD2   = 16'h2000,
    S_SCAN_CMP   = 16'h4000,
    S_EMIT_RUN   = 16'h8000
  } bwtr_state_t;

  bwtr_state_t state_r, state_nxt;

  assign in_stall = state_r != S_LOAD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load_en = 1'b1;
          if (in_end_of_line) state_nxt = S_I_INIT;
        end
      end
      S_I_INIT: begin
        cmd.i_init = 1'b1;
        state_nxt  = S_J_INIT;
      end
      S_J_INIT: begin
        cmd.j_init = 1'b1;
        state_nxt  = S_RD;
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        if (sts.cmp_lt || sts.cmp_gt || sts.cmp_end) state_nxt = S_J_NEXT;
        else state_nxt = S_RD;
      end
      S_J_NEXT: begin
        if (sts.j_last) begin
          state_nxt = S_LAST_SET;
        end else begin
          cmd.j_next = 1'b1;
          state_nxt  = S_J_INIT;
        end
      end
      S_LAST_SET: begin
        cmd.last_set = 1'b1;
        state_nxt    = S_LAST_RD;
      end
      S_LAST_RD: state_nxt = S_LAST_WR;
      S_LAST_WR: begin
        cmd.last_wr = 1'b1;
        state_nxt   = sts.i_last ? S_EMIT_PIDX : S_I_INIT;
      end
      S_EMIT_PIDX: begin
        if (sts.out_free) begin
          cmd.emit_pidx = 1'b1;
          state_nxt     = S_SCAN_INIT;
        end
      end
      S_SCAN_INIT: begin
        cmd.scan_init = 1'b1;
        state_nxt     = S_SCAN_RD;
      end
      S_SCAN_RD: state_nxt = S_SCAN_FIRST;
      S_SCAN_FIRST: begin
        cmd.scan_first = 1'b1;
        state_nxt      = sts.scan_end ? S_EMIT_RUN : S_SCAN_RD2;
      end
      S_SCAN_RD2: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        if (!sts.sym_match || sts.scan_end) state_nxt = S_EMIT_RUN;
        else state_nxt = S_SCAN_RD2;
      end
      S_EMIT_RUN: begin
        if (sts.out_free) begin
          cmd.emit_run = 1'b1;
          state_nxt    = sts.run_final ? S_LOAD : S_SCAN_FIRST;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

endmodule

// ----- design/bwt_encoder_with_run_lengths.sv -----
// ----------------------------------------------------------------------------
// bwt_encoder_with_run_lengths
// Bytes without end mark are stored as they are accepted. At line end, the n
// rotations are ranked one byte compare at a time (each pair of bytes is read
// through the line store read ports, then compared), the last column is built,
// then the scan compares each last-column byte and emits a result per run, held back under output stalls.
// One line is worked on at a time; bytes are held off until its last result.
// Reset: synchronous, active low; clears line length, overflow flag and
// output valid, and returns to loading.
// ----------------------------------------------------------------------------
module bwt_encoder_with_run_lengths
  import bwtr_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_end_of_line,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_kind,
  output logic [PIDX_W-1:0] out_primary_index,
  output logic [CNT_W-1:0]  out_run_count,
  output logic [BYTE_W-1:0] out_run_symbol,
  output logic              out_truncated,
  output logic              out_final_result
);

  bwtr_cmd_t cmd;
  bwtr_sts_t sts;

  bwtr_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_end_of_line (in_end_of_line),
    .in_stall       (in_stall),
    .sts            (sts),
    .cmd            (cmd)
  );

  bwtr_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_data_byte      (in_data_byte),
    .in_end_of_line    (in_end_of_line),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_primary_index (out_primary_index),
    .out_run_count     (out_run_count),
    .out_run_symbol    (out_run_symbol),
    .out_truncated     (out_truncated),
    .out_final_result  (out_final_result)
  );

endmodule

// ----- test/bwt_encoder_with_run_lengths_checker.sv -----
// ----------------------------------------------------------------------------
// bwt_encoder_with_run_lengths_checker
// Watches the byte and result channels of the block-sorting encoder. It
// collects each line as its bytes are accepted, and at the end-marked byte it
// ranks the rotations and queues the primary index and the run pairs of the
// last column. It compares each accepted result with the oldest queued one
// and counts mismatches.
// ----------------------------------------------------------------------------
module bwt_encoder_with_run_lengths_checker
  import bwtr_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_end_of_line,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_kind,
  input  logic [PIDX_W-1:0] out_primary_index,
  input  logic [CNT_W-1:0]  out_run_count,
  input  logic [BYTE_W-1:0] out_run_symbol,
  input  logic              out_truncated,
  input  logic              out_final_result,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic              kind;
    logic [PIDX_W-1:0] pidx;
    logic [CNT_W-1:0]  cnt;
    logic [BYTE_W-1:0] sym;
    logic              trunc;
    logic              fin;
  } bwt_result_t;

  localparam logic KIND_PIDX = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  logic [BYTE_W-1:0] line_bytes[MAX_LEN];
  int                line_len;
  logic              dropped;
  bwt_result_t       expected_q[$];

  function automatic int rotation_compare(int a, int b, int n);
    for (int k = 0; k < n; k++) begin
      if (line_bytes[(a + k) % n] < line_bytes[(b + k) % n]) return -1;
      if (line_bytes[(a + k) % n] > line_bytes[(b + k) % n]) return 1;
    end
    return 0;
  endfunction

  task automatic predict_line();
    int          order[MAX_LEN];
    int          n, j, cur, pidx, i, cnt;
    logic [7:0]  tail[MAX_LEN];
    bwt_result_t r;
    n = line_len;
    for (i = 0; i < n; i++) order[i] = i;
    for (i = 1; i < n; i++) begin
      cur = order[i];
      j = i;
      while (j > 0 && rotation_compare(order[j-1], cur, n) > 0) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    pidx = 0;
    for (i = n - 1; i >= 0; i--)
      if (rotation_compare(order[i], 0, n) == 0) pidx = i;
    for (i = 0; i < n; i++) tail[i] = line_bytes[(order[i] + n - 1) % n];
    r = '{KIND_PIDX, pidx[PIDX_W-1:0], '0, '0, dropped, 1'b0};
    expected_q.push_back(r);
    i = 0;
    while (i < n) begin
      cnt = 1;
      while (i + cnt < n && tail[i+cnt] == tail[i]) cnt++;
      r = '{KIND_RUN, '0, cnt[CNT_W-1:0], tail[i], dropped, (i + cnt >= n)};
      expected_q.push_back(r);
      i += cnt;
    end
    line_len = 0;
    dropped  = 1'b0;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    line_len   = 0;
    dropped    = 1'b0;
  end

  assign pending = expected_q.size();

  always @(posedge clk) begin
    bwt_result_t w;
    if (!rst_n) begin
      line_len = 0;
      dropped  = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          w = expected_q.pop_front();
          if (out_kind !== w.kind) report_mismatch("kind", out_kind, w.kind);
          if (out_primary_index !== w.pidx)
            report_mismatch("primary index", out_primary_index, w.pidx);
          if (out_run_count !== w.cnt) report_mismatch("run count", out_run_count, w.cnt);
          if (out_run_symbol !== w.sym)
            report_mismatch("run symbol", out_run_symbol, w.sym);
          if (out_truncated !== w.trunc)
            report_mismatch("truncated", out_truncated, w.trunc);
          if (out_final_result !== w.fin)
            report_mismatch("final", out_final_result, w.fin);
        end
      end
      if (in_valid && !in_stall) begin
        if (line_len < MAX_LEN) begin
          line_bytes[line_len] = in_data_byte;
          line_len++;
        end else begin
          dropped = 1'b1;
        end
        if (in_end_of_line) predict_line();
      end
    end
  end

endmodule

// ----- test/bwt_encoder_with_run_lengths_test.sv -----
// ----------------------------------------------------------------------------
// bwt_encoder_with_run_lengths_test
// Drives lines of bytes into the encoder in bursts with random gaps while the
// result side stalls on its own pattern. Directed lines cover single bytes,
// extreme byte values, periodic lines, full and over-long lines; random lines
// follow, mostly short, a few near or beyond capacity.
// ----------------------------------------------------------------------------
module bwt_encoder_with_run_lengths_test;
  import bwtr_pkg::*;

  localparam int MAX_LEN = MAX_LEN_DEF;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] in_data_byte;
  logic              in_end_of_line;
  logic              out_valid;
  logic              out_stall;
  logic              out_kind;
  logic [PIDX_W-1:0] out_primary_index;
  logic [CNT_W-1:0]  out_run_count;
  logic [BYTE_W-1:0] out_run_symbol;
  logic              out_truncated;
  logic              out_final_result;
  int                fail_count;
  int                pending;
  int                burst_left;
  int                items_sent;
  logic              stall_mode;

  bwt_encoder_with_run_lengths #(.MAX_LEN(MAX_LEN)) u_dut (.*);

  bwt_encoder_with_run_lengths_checker #(.MAX_LEN(MAX_LEN)) u_checker (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    out_stall <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b0;
  end

  task automatic send_byte(logic [7:0] b, logic eol);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap != 0) in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_line <= eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_line(int len, int mode, logic [7:0] base);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: b = 8'($urandom_range(0, 255));
        1: b = base;
        2: b = (i % 2) ? ~base : base;
        3: b = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
        default: b = base + 8'($urandom_range(0, 2));
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_end_of_line = 1'b0;
    out_stall = 1'b0;
    stall_mode = 1'b0;
    burst_left = 0;
    items_sent = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    send_line(1, 1, 8'h00);
    send_line(1, 1, 8'hFF);
    send_line(2, 2, 8'h00);
    send_line(4, 1, 8'hA5);
    send_line(6, 2, 8'h5A);
    send_line(5, 3, 8'h00);
    send_line(3, 0, 8'h00);
    send_line(MAX_LEN, 0, 8'h00);
    send_line(MAX_LEN + 3, 4, 8'h80);
    while (items_sent < 250) begin
      case ($urandom_range(0, 9))
        0: send_line($urandom_range(MAX_LEN - 1, MAX_LEN + 4),
                     $urandom_range(0, 4), 8'($urandom_range(0, 255)));
        default: send_line($urandom_range(1, 10), $urandom_range(0, 4),
                           8'($urandom_range(0, 255)));
      endcase
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #40000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
